FILE: src/svpwm_modulator_assert.svh
// ----------------------------------------------------------------------------
// svpwm_modulator_assert.svh
// Assertion macros shared by the modulator RTL. All are clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SVPWM_MODULATOR_ASSERT_SVH
`define SVPWM_MODULATOR_ASSERT_SVH

// Same-cycle implication.
`define SVPWM_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// Next-cycle implication.
`define SVPWM_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

FILE: src/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Types, fixed-point widths, register codes and the quarter-wave sine table
// of the space-vector PWM modulator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

	localparam int SINE_TABLE_ENTRIES = 1024;
	localparam int TRIG_BITS          = 16;
	localparam int TRIG_FRAC          = TRIG_BITS - 1;
	localparam int PH_FRAC            = 8;

	localparam int SINE_DEPTH = SINE_TABLE_ENTRIES + 1;
	localparam int SINE_AW    = $clog2(SINE_DEPTH);

	// datapath widths, all signed unless noted
	localparam int TRIG_W   = TRIG_FRAC + 1;
	localparam int PROD_W   = 16 + TRIG_W;
	localparam int AB_W     = PROD_W + 1;
	localparam int BPROD_W  = AB_W + 17;
	localparam int PH_SUM_W = BPROD_W + 1;
	localparam int PH_SHIFT = 16 + TRIG_FRAC - PH_FRAC;
	localparam int PH_W     = PH_SUM_W - PH_SHIFT;
	localparam int GAIN_W   = 24;
	localparam int GPROD_W  = PH_W + GAIN_W + 1;
	localparam int K_W      = GPROD_W - PH_FRAC;
	localparam int T_W      = K_W + 4;

	localparam int TIME_ONE  = 65536;
	localparam int TIME_HALF = TIME_ONE / 2;

	// sqrt3/2 in Q16
	localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;
	localparam longint unsigned    HALF_PI_Q30    = 64'd1686629713;

	// Taylor series divisors (2k)(2k+1) for k = 1..8
	localparam longint unsigned TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210, 64'd272};

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = GAIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CMP_MIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CMP_MAX  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BUS_GAIN = 2'd3;

	localparam logic [15:0]       PERIOD_RST   = 16'd5000;
	localparam logic [15:0]       CMP_MIN_RST  = 16'd0;
	localparam logic [15:0]       CMP_MAX_RST  = 16'd5000;
	localparam logic [GAIN_W-1:0] BUS_GAIN_RST = 24'd65536;

	// sector codes 4C+2B+A, letters name the positive phases
	localparam logic [2:0] SEC_NONE = 3'd0;
	localparam logic [2:0] SEC_U    = 3'd1;
	localparam logic [2:0] SEC_V    = 3'd2;
	localparam logic [2:0] SEC_UV   = 3'd3;
	localparam logic [2:0] SEC_W    = 3'd4;
	localparam logic [2:0] SEC_UW   = 3'd5;
	localparam logic [2:0] SEC_VW   = 3'd6;
	localparam logic [2:0] SEC_UVW  = 3'd7;

	typedef struct packed {
		logic signed [15:0] volt_d;
		logic signed [15:0] volt_q;
		logic [15:0]        elec_angle;
	} cmd_t;

	typedef struct packed {
		logic [15:0] cmp_u;
		logic [15:0] cmp_v;
		logic [15:0] cmp_w;
		logic [2:0]  sector_code;
	} res_t;

	typedef logic [TRIG_FRAC-1:0] sine_tab_t [SINE_DEPTH];

	// Q30 Taylor series to the x^17 term, truncating each step, rounded to QF
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t       tab;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint          v;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			x    = (longint'(i) * HALF_PI_Q30) / SINE_TABLE_ENTRIES;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int k = 1; k <= 8; k++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
				if ((k & 1) != 0)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			if (sum > (longint'(1) << 30))
				sum = longint'(1) << 30;
			v = (sum + (longint'(1) << (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
			if (v > (longint'(1) << TRIG_FRAC) - 1)
				v = (longint'(1) << TRIG_FRAC) - 1;
			tab[i] = v[TRIG_FRAC-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: src/svpwm_ram.sv
// ----------------------------------------------------------------------------
// svpwm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module svpwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: src/svpwm_modulator.sv
// ----------------------------------------------------------------------------
// svpwm_modulator
// Space-vector PWM modulator: inverse Park, inverse Clarke, sector decode,
// active-vector times and saturated compare values for three phases.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries volt_d, volt_q, elec_angle.
//   res channel (res_valid/res_ready/res) returns cmp_u/v/w and sector_code,
//   one result per command, in order.
//   cfg_we/cfg_index/cfg_wdata write period_counts, cmp_min, cmp_max and
//   bus_gain, one register per write; write them only while no command is in flight.
// Timing:
//   11-stage pipeline, stage 1 to stage 11, the last one being the output register.
//   One command per cycle sustained while res_ready is high; the two table lookups use
//   one read port each of the sine RAM, and the multiplies are registered in stages 2, 4, 6 and 10.
// Reset:
//   Config and control registers return to their reset values and the sine RAM
//   is loaded from the package table, one entry a cycle: cmd_ready stays low
//   until the load is done. Config writes are taken during the load.
// Stall:
//   Each stage holds while the next one is full and stalled; bubbles are
//   squeezed out, so commands keep flowing until the pipeline is full.
// ----------------------------------------------------------------------------
module svpwm_modulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  svpwm_pkg::cmd_t                     cmd,
	output logic                                res_valid,
	input  logic                                res_ready,
	output svpwm_pkg::res_t                     res,
	input  logic                                cfg_we,
	input  logic [svpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [svpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

`include "svpwm_modulator_assert.svh"

	localparam int NSTG = 11;
	localparam int SAW  = svpwm_pkg::SINE_AW;
	localparam int TF   = svpwm_pkg::TRIG_FRAC;
	localparam int TW   = svpwm_pkg::T_W;
	localparam logic [15:0] QUARTER_TURN = 16'd16384;
	localparam logic signed [TW-1:0] T_ONE  = TW'(svpwm_pkg::TIME_ONE);
	localparam logic signed [TW-1:0] T_HALF = TW'(svpwm_pkg::TIME_HALF);

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------
	function automatic logic [SAW-1:0] trig_index(input logic [15:0] ang);
		logic [14:0]         p_ref;
		logic [15+SAW-1:0]   prod;
		p_ref = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
		prod  = (15 + SAW)'(p_ref) * (15 + SAW)'(svpwm_pkg::SINE_TABLE_ENTRIES);
		return prod[14+SAW-1:14];
	endfunction

	function automatic logic [16:0] clamp_time(input logic signed [TW-1:0] t);
		if (t < 0)
			return 17'd0;
		else if (t > T_ONE)
			return 17'(svpwm_pkg::TIME_ONE);
		return t[16:0];
	endfunction

	function automatic logic [15:0] sat_cmp(input logic [15:0] c, input logic [15:0] lo,
			input logic [15:0] hi);
		if (c < lo)
			return lo;
		else if (c > hi)
			return hi;
		return c;
	endfunction

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [15:0]                   period_q;
	logic [15:0]                   cmp_min_q;
	logic [15:0]                   cmp_max_q;
	logic [svpwm_pkg::GAIN_W-1:0]  bus_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= svpwm_pkg::PERIOD_RST;
			cmp_min_q  <= svpwm_pkg::CMP_MIN_RST;
			cmp_max_q  <= svpwm_pkg::CMP_MAX_RST;
			bus_gain_q <= svpwm_pkg::BUS_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				svpwm_pkg::REG_PERIOD:   period_q   <= cfg_wdata[15:0];
				svpwm_pkg::REG_CMP_MIN:  cmp_min_q  <= cfg_wdata[15:0];
				svpwm_pkg::REG_CMP_MAX:  cmp_max_q  <= cfg_wdata[15:0];
				svpwm_pkg::REG_BUS_GAIN: bus_gain_q <= cfg_wdata[svpwm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// sine RAM load after reset
	// ------------------------------------------------------------------
	logic [SAW-1:0] fill_cnt_q;
	logic           fill_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q  <= '0;
			fill_done_q <= 1'b0;
		end else if (!fill_done_q) begin
			if (fill_cnt_q == SAW'(svpwm_pkg::SINE_DEPTH - 1))
				fill_done_q <= 1'b1;
			else
				fill_cnt_q <= fill_cnt_q + 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// pipeline control
	// ------------------------------------------------------------------
	logic [NSTG:1] stage_vld_q;
	logic [NSTG:1] stage_en;

	always_comb begin
		stage_en[NSTG] = !stage_vld_q[NSTG] || res_ready;
		for (int k = NSTG - 1; k >= 1; k--)
			stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
	end

	assign cmd_ready = fill_done_q && stage_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[1])
				stage_vld_q[1] <= cmd_valid && cmd_ready;
			for (int k = 2; k <= NSTG; k++)
				if (stage_en[k])
					stage_vld_q[k] <= stage_vld_q[k-1];
		end
	end

	// ------------------------------------------------------------------
	// stage 1: quarter-wave lookups
	// ------------------------------------------------------------------
	logic [15:0]    cos_angle;
	logic [TF-1:0]  sin_mag;
	logic [TF-1:0]  cos_mag;

	assign cos_angle = cmd.elec_angle + QUARTER_TURN;

	svpwm_ram #(
		.WIDTH(TF),
		.DEPTH(svpwm_pkg::SINE_DEPTH)
	) u_sine_ram (
		.clk     (clk),
		.we      (!fill_done_q),
		.waddr   (fill_cnt_q),
		.wdata   (svpwm_pkg::SINE_TAB[fill_cnt_q]),
		.re      (stage_en[1]),
		.raddr_a (trig_index(cmd.elec_angle)),
		.raddr_b (trig_index(cos_angle)),
		.rdata_a (sin_mag),
		.rdata_b (cos_mag)
	);

	logic signed [15:0] d_s1;
	logic signed [15:0] q_s1;
	logic               sneg_s1;
	logic               cneg_s1;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			d_s1    <= cmd.volt_d;
			q_s1    <= cmd.volt_q;
			sneg_s1 <= cmd.elec_angle[15];
			cneg_s1 <= cos_angle[15];
		end
	end

	// ------------------------------------------------------------------
	// stage 2: rotation products
	// ------------------------------------------------------------------
	logic signed [svpwm_pkg::TRIG_W-1:0] sin_v;
	logic signed [svpwm_pkg::TRIG_W-1:0] cos_v;
	logic signed [svpwm_pkg::PROD_W-1:0] dc_s2, qs_s2, ds_s2, qc_s2;

	always_comb begin
		sin_v = $signed({1'b0, sin_mag});
		cos_v = $signed({1'b0, cos_mag});
		if (sneg_s1)
			sin_v = -sin_v;
		if (cneg_s1)
			cos_v = -cos_v;
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			dc_s2 <= d_s1 * cos_v;
			qs_s2 <= q_s1 * sin_v;
			ds_s2 <= d_s1 * sin_v;
			qc_s2 <= q_s1 * cos_v;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: alpha / beta
	// ------------------------------------------------------------------
	logic signed [svpwm_pkg::AB_W-1:0] alpha_s3, beta_s3;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			alpha_s3 <= svpwm_pkg::AB_W'(dc_s2) - svpwm_pkg::AB_W'(qs_s2);
			beta_s3  <= svpwm_pkg::AB_W'(ds_s2) + svpwm_pkg::AB_W'(qc_s2);
		end
	end

	// ------------------------------------------------------------------
	// stage 4: U phase, beta * sqrt3/2
	// ------------------------------------------------------------------
	logic signed [svpwm_pkg::PH_W-1:0]    ua_s4;
	logic signed [svpwm_pkg::AB_W-1:0]    alpha_s4;
	logic signed [svpwm_pkg::BPROD_W-1:0] bprod_s4;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			ua_s4    <= svpwm_pkg::PH_W'(alpha_s3 >>> (TF - svpwm_pkg::PH_FRAC));
			alpha_s4 <= alpha_s3;
			bprod_s4 <= svpwm_pkg::BPROD_W'(beta_s3) * svpwm_pkg::SQRT3_HALF_Q16;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: V and W phases
	// ------------------------------------------------------------------
	logic signed [svpwm_pkg::PH_SUM_W-1:0] a15;
	logic signed [svpwm_pkg::PH_SUM_W-1:0] bwide;
	logic signed [svpwm_pkg::PH_SUM_W-1:0] ub_sum, uc_sum;
	logic signed [svpwm_pkg::PH_W-1:0]     ua_s5, ub_s5, uc_s5;

	always_comb begin
		a15    = svpwm_pkg::PH_SUM_W'(alpha_s4) <<< 15;
		bwide  = svpwm_pkg::PH_SUM_W'(bprod_s4);
		ub_sum = bwide - a15;
		uc_sum = -bwide - a15;
	end

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			ua_s5 <= ua_s4;
			ub_s5 <= svpwm_pkg::PH_W'(ub_sum >>> svpwm_pkg::PH_SHIFT);
			uc_s5 <= svpwm_pkg::PH_W'(uc_sum >>> svpwm_pkg::PH_SHIFT);
		end
	end

	// ------------------------------------------------------------------
	// stage 6: sector code, bus gain scaling
	// ------------------------------------------------------------------
	logic signed [svpwm_pkg::GAIN_W:0]    gain_s;
	logic signed [svpwm_pkg::GPROD_W-1:0] ga_s6, gb_s6, gc_s6;
	logic [2:0]                           sector_s6;

	assign gain_s = $signed({1'b0, bus_gain_q});

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			ga_s6     <= gain_s * ua_s5;
			gb_s6     <= gain_s * ub_s5;
			gc_s6     <= gain_s * uc_s5;
			sector_s6 <= {uc_s5 > 0, ub_s5 > 0, ua_s5 > 0};
		end
	end

	// ------------------------------------------------------------------
	// stage 7: active-vector times for the sector
	// ------------------------------------------------------------------
	logic signed [TW-1:0] ka, kb, kc;
	logic signed [TW-1:0] tx, ty;
	logic signed [TW-1:0] tx_s7, ty_s7;
	logic [2:0]           sector_s7;

	always_comb begin
		ka = TW'(ga_s6 >>> svpwm_pkg::PH_FRAC);
		kb = TW'(gb_s6 >>> svpwm_pkg::PH_FRAC);
		kc = TW'(gc_s6 >>> svpwm_pkg::PH_FRAC);
		case (sector_s6)
			svpwm_pkg::SEC_UV: begin tx = kb;  ty = ka;  end
			svpwm_pkg::SEC_U:  begin tx = -kb; ty = -kc; end
			svpwm_pkg::SEC_UW: begin tx = ka;  ty = kc;  end
			svpwm_pkg::SEC_W:  begin tx = -ka; ty = -kb; end
			svpwm_pkg::SEC_VW: begin tx = kc;  ty = kb;  end
			svpwm_pkg::SEC_V:  begin tx = -kc; ty = -ka; end
			default:           begin tx = '0;  ty = '0;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			tx_s7     <= tx;
			ty_s7     <= ty;
			sector_s7 <= sector_s6;
		end
	end

	// ------------------------------------------------------------------
	// stage 8: zero-vector half time
	// ------------------------------------------------------------------
	logic signed [TW-1:0] base_s8, tx_s8, ty_s8;
	logic [2:0]           sector_s8;

	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			base_s8   <= (T_ONE - tx_s7 - ty_s7) >>> 1;
			tx_s8     <= tx_s7;
			ty_s8     <= ty_s7;
			sector_s8 <= sector_s7;
		end
	end

	// ------------------------------------------------------------------
	// stage 9: phase times, clamped to one period
	// ------------------------------------------------------------------
	logic signed [TW-1:0] b1, b2;
	logic signed [TW-1:0] t1, t2, t3;
	logic [16:0]          tu_s9, tv_s9, tw_s9;
	logic [2:0]           sector_s9;

	always_comb begin
		b1 = base_s8 + ty_s8;
		b2 = base_s8 + ty_s8 + tx_s8;
		case (sector_s8)
			svpwm_pkg::SEC_UV: begin t3 = base_s8; t2 = b1; t1 = b2; end
			svpwm_pkg::SEC_U:  begin t3 = base_s8; t1 = b1; t2 = b2; end
			svpwm_pkg::SEC_UW: begin t1 = base_s8; t3 = b1; t2 = b2; end
			svpwm_pkg::SEC_W:  begin t1 = base_s8; t2 = b1; t3 = b2; end
			svpwm_pkg::SEC_VW: begin t2 = base_s8; t1 = b1; t3 = b2; end
			svpwm_pkg::SEC_V:  begin t2 = base_s8; t3 = b1; t1 = b2; end
			// null sectors: 50% on all phases
			default:           begin t1 = T_HALF; t2 = T_HALF; t3 = T_HALF; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			tu_s9     <= clamp_time(t1);
			tv_s9     <= clamp_time(t2);
			tw_s9     <= clamp_time(t3);
			sector_s9 <= sector_s8;
		end
	end

	// ------------------------------------------------------------------
	// stage 10: scale to compare counts
	// ------------------------------------------------------------------
	logic [32:0] cu_s10, cv_s10, cw_s10;
	logic [2:0]  sector_s10;

	always_ff @(posedge clk) begin
		if (stage_en[10]) begin
			cu_s10     <= 33'(tu_s9) * 33'(period_q);
			cv_s10     <= 33'(tv_s9) * 33'(period_q);
			cw_s10     <= 33'(tw_s9) * 33'(period_q);
			sector_s10 <= sector_s9;
		end
	end

	// ------------------------------------------------------------------
	// stage 11: saturation, output register
	// ------------------------------------------------------------------
	svpwm_pkg::res_t res_s11;

	always_ff @(posedge clk) begin
		if (stage_en[11]) begin
			res_s11.cmp_u       <= sat_cmp(cu_s10[31:16], cmp_min_q, cmp_max_q);
			res_s11.cmp_v       <= sat_cmp(cv_s10[31:16], cmp_min_q, cmp_max_q);
			res_s11.cmp_w       <= sat_cmp(cw_s10[31:16], cmp_min_q, cmp_max_q);
			res_s11.sector_code <= sector_s10;
		end
	end

	assign res_valid = stage_vld_q[NSTG];
	assign res       = res_s11;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`SVPWM_ASSERT_NOW(a_no_transfer_in_fill, !fill_done_q, !cmd_ready, "cmd transfer during table load")
	`SVPWM_ASSERT_NOW(a_null_sector_equal, res_valid && (res.sector_code == svpwm_pkg::SEC_NONE || res.sector_code == svpwm_pkg::SEC_UVW), res.cmp_u == res.cmp_v && res.cmp_v == res.cmp_w, "null sector with unequal compares")
	`SVPWM_ASSERT_NEXT(a_stage_hold, stage_vld_q[NSTG-1] && !stage_en[NSTG-1], stage_vld_q[NSTG-1], "stalled stage lost its item")

endmodule
